FILE: src/assert_macros.svh
// shared assertion macros, clocked on clock and quiet during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CHK_IMPLY(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

// next-cycle implication
`define CHK_NEXT(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

FILE: src/lag12_pkg.sv
package lag12_pkg;

   localparam int NODE_COUNT   = 12;
   localparam int SAMPLE_WIDTH = 16;
   localparam int IDX_W        = $clog2(NODE_COUNT);

   localparam int X_W    = 16;
   localparam int D_W    = X_W + 1;
   localparam int XFRAC  = 12;
   localparam int WFRAC  = 20;
   localparam int OUT_W  = 24;

   // weight magnitude, clamped at 2^(WMAG_W-1)
   localparam int WMAG_W   = 45;
   localparam int MUL_A_W  = (WMAG_W + 1) / 2;
   localparam int MUL_B_W  = (SAMPLE_WIDTH > X_W) ? SAMPLE_WIDTH : X_W;
   localparam int PROD_W   = MUL_A_W + MUL_B_W;
   localparam int MAG_W    = 2 * MUL_A_W + MUL_B_W;
   localparam int TERM_W   = MAG_W - WFRAC;
   localparam int ACC_W    = TERM_W + $clog2(NODE_COUNT) + 1;

   localparam int DIV_STEP   = 8;
   localparam int DIV_W      = ((MAG_W - XFRAC + DIV_STEP - 1) / DIV_STEP) * DIV_STEP;
   localparam int DIV_CYCLES = DIV_W / DIV_STEP;
   localparam int DCNT_W     = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;

   localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'((64'sd1 <<< (OUT_W - 1)) - 64'sd1);
   localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);

   localparam logic REQ_LOAD = 1'b0;
   localparam logic REQ_EVAL = 1'b1;

   typedef struct packed {
      logic               req_type;
      logic [3:0]         node_index;
      logic signed [15:0] node_value;
      logic [15:0]        eval_point;
   } req_word_type;

   typedef struct packed {
      logic signed [OUT_W-1:0] interp_value;
      logic                    saturated;
   } rsp_word_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_LO,
      ST_MUL_HI,
      ST_SUM,
      ST_DIV,
      ST_TERM_LO,
      ST_TERM_HI,
      ST_TERM_RND,
      ST_ACC,
      ST_DONE
   } state_type;

endpackage

FILE: src/lagrange_interpolator_12pt.sv
// evaluate: result strobe once all twelve node terms are accumulated and saturated; busy drops
// with the strobe, and no new evaluation is taken before then; results cannot be held off
// load: taken only while idle, busy stays low, no result word
// pace set by the single 23x16 multiplier (two passes per product) and the
// 8-bit-per-cycle divide by |i-j|, eleven weight steps per node
// synchronous active-high reset: idle, no strobe, every stored sample reads as zero
`include "assert_macros.svh"

module lagrange_interpolator_12pt (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  lag12_pkg::req_word_type req_word,
   output logic                    rsp_strobe,
   output lag12_pkg::rsp_word_type rsp_word
);

   lag12_pkg::state_type state_ff, state_in;

   // sample store
   logic signed [lag12_pkg::SAMPLE_WIDTH-1:0] sample_mem [lag12_pkg::NODE_COUNT];
   logic [lag12_pkg::NODE_COUNT-1:0]          sample_vld_ff;
   logic [lag12_pkg::SAMPLE_WIDTH-1:0]        rd_data_ff;
   logic                                      rd_vld_ff;
   logic                                      load_we;

   logic [lag12_pkg::X_W-1:0]    x_ff, x_in;
   logic [lag12_pkg::IDX_W-1:0]  i_ff, i_in;
   logic [lag12_pkg::IDX_W-1:0]  j_ff, j_in;
   logic [lag12_pkg::WMAG_W-1:0] wm_ff, wm_in;
   logic                         wneg_ff, wneg_in;
   logic [lag12_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic [lag12_pkg::PROD_W-1:0] part_ff;
   logic [lag12_pkg::DIV_W-1:0]  num_ff, num_in;
   logic [lag12_pkg::IDX_W-1:0]  rem_ff, rem_in;
   logic [lag12_pkg::DCNT_W-1:0] dcnt_ff, dcnt_in;
   logic [lag12_pkg::TERM_W-1:0] term_ff, term_in;
   logic                         tneg_ff, tneg_in;
   logic signed [lag12_pkg::ACC_W-1:0] acc_ff, acc_in;
   logic                         rsp_strobe_ff, rsp_strobe_in;
   lag12_pkg::rsp_word_type      rsp_word_ff, rsp_word_in;

   // datapath
   logic signed [lag12_pkg::D_W-1:0]     d_full, dm_full;
   logic                                 d_neg;
   logic [lag12_pkg::X_W-1:0]            dm;
   logic                                 i_lt_j;
   logic [lag12_pkg::IDX_W-1:0]          k;
   logic [lag12_pkg::SAMPLE_WIDTH-1:0]   y, ym;
   logic                                 y_neg;
   logic [lag12_pkg::MUL_A_W-1:0]        mul_a;
   logic [lag12_pkg::MUL_B_W-1:0]        mul_b;
   logic [lag12_pkg::MAG_W-1:0]          rnd_val, mag_sum;
   logic [lag12_pkg::IDX_W:0]            trial, j_p1, j_nx;
   logic [lag12_pkg::IDX_W-1:0]          div_r;
   logic [lag12_pkg::DIV_W-1:0]          div_n;
   logic                                 q_big, j_last;
   logic [lag12_pkg::WMAG_W-1:0]         wm_clamp;
   logic signed [lag12_pkg::ACC_W-1:0]   term_ext;

   assign busy       = (state_ff != lag12_pkg::ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_word   = rsp_word_ff;

   assign load_we = start && !busy && (req_word.req_type == lag12_pkg::REQ_LOAD) &&
                    ({1'b0, req_word.node_index} < 5'(lag12_pkg::NODE_COUNT));

   always_ff @(posedge clock) begin
      if (load_we) begin
         sample_mem[req_word.node_index[lag12_pkg::IDX_W-1:0]] <=
            req_word.node_value[lag12_pkg::SAMPLE_WIDTH-1:0];
      end
      rd_data_ff <= sample_mem[i_ff];
      rd_vld_ff  <= sample_vld_ff[i_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_vld_ff <= '0;
      end else if (load_we) begin
         sample_vld_ff[req_word.node_index[lag12_pkg::IDX_W-1:0]] <= 1'b1;
      end
   end

   // x - j in Q4.12 and the divisor |i - j|
   always_comb begin
      d_full  = signed'({1'b0, x_ff}) -
                signed'(lag12_pkg::D_W'({j_ff, {lag12_pkg::XFRAC{1'b0}}}));
      d_neg   = d_full[lag12_pkg::D_W-1];
      dm_full = d_neg ? -d_full : d_full;
      dm      = dm_full[lag12_pkg::X_W-1:0];
      i_lt_j  = (i_ff < j_ff);
      k       = i_lt_j ? (j_ff - i_ff) : (i_ff - j_ff);
      y       = rd_vld_ff ? rd_data_ff : '0;
      y_neg   = y[lag12_pkg::SAMPLE_WIDTH-1];
      ym      = y_neg ? (~y + 1'b1) : y;
   end

   // shared multiplier, low half of the weight first, then the high half
   always_comb begin
      if (state_ff == lag12_pkg::ST_MUL_HI || state_ff == lag12_pkg::ST_TERM_HI) begin
         mul_a = lag12_pkg::MUL_A_W'(wm_ff[lag12_pkg::WMAG_W-1:lag12_pkg::MUL_A_W]);
      end else begin
         mul_a = wm_ff[lag12_pkg::MUL_A_W-1:0];
      end
      if (state_ff == lag12_pkg::ST_TERM_LO || state_ff == lag12_pkg::ST_TERM_HI) begin
         mul_b = lag12_pkg::MUL_B_W'(ym);
      end else begin
         mul_b = lag12_pkg::MUL_B_W'(dm);
      end
      prod_in = lag12_pkg::PROD_W'(mul_a) * lag12_pkg::PROD_W'(mul_b);
   end

   // combine halves plus rounding offset
   always_comb begin
      if (state_ff == lag12_pkg::ST_SUM) begin
         rnd_val = lag12_pkg::MAG_W'(k) << (lag12_pkg::XFRAC - 1);
      end else begin
         rnd_val = lag12_pkg::MAG_W'(1) << (lag12_pkg::WFRAC - 1);
      end
      mag_sum = {prod_ff, {lag12_pkg::MUL_A_W{1'b0}}} + lag12_pkg::MAG_W'(part_ff) + rnd_val;
   end

   // restoring divide by k, several quotient bits a cycle
   always_comb begin
      div_r = rem_ff;
      div_n = num_ff;
      trial = '0;
      for (int b = 0; b < lag12_pkg::DIV_STEP; b++) begin
         trial = {div_r, div_n[lag12_pkg::DIV_W-1]};
         if (trial >= {1'b0, k}) begin
            div_r = lag12_pkg::IDX_W'(trial - {1'b0, k});
            div_n = {div_n[lag12_pkg::DIV_W-2:0], 1'b1};
         end else begin
            div_r = trial[lag12_pkg::IDX_W-1:0];
            div_n = {div_n[lag12_pkg::DIV_W-2:0], 1'b0};
         end
      end
      q_big = (|div_n[lag12_pkg::DIV_W-1:lag12_pkg::WMAG_W]) ||
              (div_n[lag12_pkg::WMAG_W-1] && (|div_n[lag12_pkg::WMAG_W-2:0]));
      wm_clamp = q_big ? (lag12_pkg::WMAG_W'(1) << (lag12_pkg::WMAG_W - 1)) :
                         div_n[lag12_pkg::WMAG_W-1:0];
   end

   // next j, skipping the node itself
   always_comb begin
      j_p1   = {1'b0, j_ff} + 1'b1;
      j_nx   = (j_p1 == {1'b0, i_ff}) ? (j_p1 + 1'b1) : j_p1;
      j_last = (j_nx >= (lag12_pkg::IDX_W + 1)'(lag12_pkg::NODE_COUNT));
      term_ext = signed'(lag12_pkg::ACC_W'(term_ff));
   end

   always_comb begin
      state_in      = state_ff;
      x_in          = x_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      wm_in         = wm_ff;
      wneg_in       = wneg_ff;
      num_in        = num_ff;
      rem_in        = rem_ff;
      dcnt_in       = dcnt_ff;
      term_in       = term_ff;
      tneg_in       = tneg_ff;
      acc_in        = acc_ff;
      rsp_strobe_in = 1'b0;
      rsp_word_in   = rsp_word_ff;
      unique case (state_ff)
         lag12_pkg::ST_IDLE: begin
            if (start && req_word.req_type == lag12_pkg::REQ_EVAL) begin
               x_in     = req_word.eval_point;
               i_in     = '0;
               j_in     = lag12_pkg::IDX_W'(1);
               wm_in    = lag12_pkg::WMAG_W'(1) << lag12_pkg::WFRAC;
               wneg_in  = 1'b0;
               acc_in   = '0;
               state_in = lag12_pkg::ST_MUL_LO;
            end
         end
         lag12_pkg::ST_MUL_LO: begin
            state_in = lag12_pkg::ST_MUL_HI;
         end
         lag12_pkg::ST_MUL_HI: begin
            state_in = lag12_pkg::ST_SUM;
         end
         lag12_pkg::ST_SUM: begin
            num_in   = lag12_pkg::DIV_W'(mag_sum[lag12_pkg::MAG_W-1:lag12_pkg::XFRAC]);
            rem_in   = '0;
            dcnt_in  = '0;
            state_in = lag12_pkg::ST_DIV;
         end
         lag12_pkg::ST_DIV: begin
            num_in  = div_n;
            rem_in  = div_r;
            dcnt_in = dcnt_ff + 1'b1;
            if (dcnt_ff == lag12_pkg::DCNT_W'(lag12_pkg::DIV_CYCLES - 1)) begin
               wm_in   = wm_clamp;
               wneg_in = wneg_ff ^ d_neg ^ i_lt_j;
               if (j_last) begin
                  state_in = lag12_pkg::ST_TERM_LO;
               end else begin
                  j_in     = j_nx[lag12_pkg::IDX_W-1:0];
                  state_in = lag12_pkg::ST_MUL_LO;
               end
            end
         end
         lag12_pkg::ST_TERM_LO: begin
            state_in = lag12_pkg::ST_TERM_HI;
         end
         lag12_pkg::ST_TERM_HI: begin
            state_in = lag12_pkg::ST_TERM_RND;
         end
         lag12_pkg::ST_TERM_RND: begin
            term_in  = mag_sum[lag12_pkg::MAG_W-1:lag12_pkg::WFRAC];
            tneg_in  = wneg_ff ^ y_neg;
            state_in = lag12_pkg::ST_ACC;
         end
         lag12_pkg::ST_ACC: begin
            acc_in = tneg_ff ? (acc_ff - term_ext) : (acc_ff + term_ext);
            if (i_ff == lag12_pkg::IDX_W'(lag12_pkg::NODE_COUNT - 1)) begin
               state_in = lag12_pkg::ST_DONE;
            end else begin
               i_in     = i_ff + 1'b1;
               j_in     = '0;
               wm_in    = lag12_pkg::WMAG_W'(1) << lag12_pkg::WFRAC;
               wneg_in  = 1'b0;
               state_in = lag12_pkg::ST_MUL_LO;
            end
         end
         lag12_pkg::ST_DONE: begin
            rsp_strobe_in = 1'b1;
            if (acc_ff > lag12_pkg::SAT_HI) begin
               rsp_word_in.interp_value = lag12_pkg::SAT_HI[lag12_pkg::OUT_W-1:0];
               rsp_word_in.saturated    = 1'b1;
            end else if (acc_ff < lag12_pkg::SAT_LO) begin
               rsp_word_in.interp_value = lag12_pkg::SAT_LO[lag12_pkg::OUT_W-1:0];
               rsp_word_in.saturated    = 1'b1;
            end else begin
               rsp_word_in.interp_value = acc_ff[lag12_pkg::OUT_W-1:0];
               rsp_word_in.saturated    = 1'b0;
            end
            state_in = lag12_pkg::ST_IDLE;
         end
         default: begin
            state_in = lag12_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= lag12_pkg::ST_IDLE;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff        <= x_in;
      i_ff        <= i_in;
      j_ff        <= j_in;
      wm_ff       <= wm_in;
      wneg_ff     <= wneg_in;
      prod_ff     <= prod_in;
      part_ff     <= prod_ff;
      num_ff      <= num_in;
      rem_ff      <= rem_in;
      dcnt_ff     <= dcnt_in;
      term_ff     <= term_in;
      tneg_ff     <= tneg_in;
      acc_ff      <= acc_in;
      rsp_word_ff <= rsp_word_in;
   end

   `CHK_IMPLY(a_strobe_after_done, rsp_strobe_ff, $past(state_ff) == lag12_pkg::ST_DONE, "result strobe without a finished evaluation")
   `CHK_IMPLY(a_strobe_when_free, rsp_strobe_ff, !busy, "result strobe while still busy")
   `CHK_IMPLY(a_rem_below_div, state_ff == lag12_pkg::ST_DIV, rem_ff < k, "divide remainder not below divisor")
   `CHK_IMPLY(a_j_skips_i, state_ff == lag12_pkg::ST_MUL_LO, j_ff != i_ff, "weight step on the node itself")
   `CHK_NEXT(a_eval_goes_busy, start && !busy && req_word.req_type == lag12_pkg::REQ_EVAL, busy, "evaluate word accepted but block not busy")

endmodule
